// ===== sv/mtm_pkg.sv =====
// Shared types, constants and lookup functions for the MUS to MIDI event transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none
package mtm_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int DELAY_BITS   = 28;
  localparam int NGRP         = (DELAY_BITS + 6) / 7;
  localparam int NG_W         = $clog2(NGRP + 1);
  localparam int GRP_W        = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int DPAD_W       = NGRP * 7;
  localparam int STEP_W       = $clog2(NGRP + 4);
  localparam int EVQ_DEPTH    = 4;
  localparam int EVQ_PTR_W    = $clog2(EVQ_DEPTH);
  localparam int APB_ADDR_W   = 3;

  localparam logic [7:0] VOL_RESET = 8'd64;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_EVT  = 2'd1;
  localparam logic [1:0] ST_BAD_CTRL = 2'd2;
  localparam logic [1:0] ST_UNUSED   = 2'd3;

  localparam logic [2:0] EV_RELEASE   = 3'd0;
  localparam logic [2:0] EV_PLAY      = 3'd1;
  localparam logic [2:0] EV_PITCH     = 3'd2;
  localparam logic [2:0] EV_SYSTEM    = 3'd3;
  localparam logic [2:0] EV_CONTROL   = 3'd4;
  localparam logic [2:0] EV_BAD_A     = 3'd5;
  localparam logic [2:0] EV_SCORE_END = 3'd6;
  localparam logic [2:0] EV_BAD_B     = 3'd7;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CTRL     = 4'hb;
  localparam logic [3:0] CMD_PROGRAM  = 4'hc;
  localparam logic [3:0] CMD_BEND     = 4'he;

  localparam logic [7:0] META_BYTE = 8'hff;
  localparam logic [7:0] META_EOT  = 8'h2f;
  localparam logic [7:0] MAX_CTRL  = 8'd14;

  localparam logic [CH_W-1:0] MUS_PERC_CH  = CH_W'(15);
  localparam logic [CH_W-1:0] MIDI_PERC_CH = CH_W'(9);

  localparam logic [1:0] REG_INIT_VOL = 2'd0;

  typedef struct packed {
    logic [1:0]            status;
    logic                  tend;
    logic [DELAY_BITS-1:0] delay;
    logic [NG_W-1:0]       ngrp;
    logic [1:0]            nbody;
    logic [2:0][7:0]       body;
  } event_t;

  function automatic logic [7:0] ctl_map(input logic [3:0] num);
    logic [7:0] res;
    case (num)
      4'd0:    res = 8'd0;
      4'd1:    res = 8'd0;
      4'd2:    res = 8'd1;
      4'd3:    res = 8'd7;
      4'd4:    res = 8'd10;
      4'd5:    res = 8'd11;
      4'd6:    res = 8'd91;
      4'd7:    res = 8'd93;
      4'd8:    res = 8'd64;
      4'd9:    res = 8'd67;
      4'd10:   res = 8'd120;
      4'd11:   res = 8'd123;
      4'd12:   res = 8'd126;
      4'd13:   res = 8'd127;
      4'd14:   res = 8'd121;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] clamp_vol(input logic [7:0] v);
    return v[7] ? 8'h7f : v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mus_to_midi_event_transcoder_core.sv =====
// Top level of the MUS to MIDI event transcoder: configuration port, front,
// event queue and back end. Depends on mtm_pkg, mtm_front, mtm_evq, mtm_back.
//
// The block takes one MUS score byte per cycle whenever full is low and
// produces the MIDI track body one byte per cycle on a queue-style output
// while each waiting byte is popped. A completed event is handed through
// a four-entry event queue to the back end, which emits one to seven bytes
// per event, so sustained throughput is set by the back end's
// one-byte-per-cycle output register.
// The initial_volume register lies at byte address 0 and is loaded into
// all sixteen channel volumes whenever an accepted byte has score_start high.
`default_nettype none
module mus_to_midi_event_transcoder_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     mus_byte,
  input  wire logic                           score_start,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          midi_byte,
  output logic                                run_last,
  output logic                                track_end,
  output logic [1:0]                          status,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mtm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [7:0]       initial_volume;
  logic             fire, rec_valid, q_full, q_valid, q_pop, reg_hit;
  mtm_pkg::event_t  rec, q_rec;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[mtm_pkg::APB_ADDR_W-1:2] ==
                    (mtm_pkg::APB_ADDR_W-2)'(mtm_pkg::REG_INIT_VOL));
  assign prdata  = reg_hit ? {24'd0, initial_volume} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_volume <= mtm_pkg::VOL_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      initial_volume <= pwdata[7:0];
    end
  end

  assign full = q_full;
  assign fire = push && !q_full;

  mtm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .mus_byte       (mus_byte),
    .score_start    (score_start),
    .initial_volume (initial_volume),
    .rec            (rec),
    .rec_valid      (rec_valid)
  );

  mtm_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_valid),
    .wr_data  (rec),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rec),
    .rd_valid (q_valid)
  );

  mtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .midi_byte (midi_byte),
    .run_last  (run_last),
    .track_end (track_end),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== sv/mtm_front.sv =====
// Front end: accepts score bytes, tracks parse state, volumes and delay, and
// classifies each byte into at most one event record. Depends on mtm_pkg.
`default_nettype none
module mtm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       mus_byte,
  input  wire logic             score_start,
  input  wire logic [7:0]       initial_volume,
  output mtm_pkg::event_t       rec,
  output logic                  rec_valid
);

  typedef enum logic [2:0] {PH_DESC, PH_P1, PH_P2, PH_DELAY, PH_DONE} phase_t;

  phase_t                          phase, phase_next, e_phase;
  logic [mtm_pkg::CH_W-1:0]        cur_channel, cur_channel_next, mch;
  logic [2:0]                      cur_event, cur_event_next;
  logic                            group_last, group_last_next;
  logic [7:0]                      first_param, first_param_next;
  logic [mtm_pkg::DELAY_BITS-1:0]  pending_delay, pending_delay_next, e_pd;
  logic                            halted, halted_next, e_halted;
  logic [7:0]                      channel_volume [mtm_pkg::NUM_CHANNELS];
  logic                            vol_we, do_emit;
  logic [mtm_pkg::DPAD_W-1:0]      dpad;
  logic [mtm_pkg::NG_W-1:0]        ngrp;

  always_comb begin
    e_phase  = score_start ? PH_DESC : phase;
    e_halted = score_start ? 1'b0 : halted;
    e_pd     = score_start ? '0 : pending_delay;
    dpad     = mtm_pkg::DPAD_W'(e_pd);
    ngrp     = mtm_pkg::NG_W'(1);
    for (int g = 0; g < mtm_pkg::NGRP; g++) begin
      if (dpad[g*7 +: 7] != 7'd0) begin
        ngrp = mtm_pkg::NG_W'(g + 1);
      end
    end
    if (cur_channel == mtm_pkg::MUS_PERC_CH) begin
      mch = mtm_pkg::MIDI_PERC_CH;
    end else if (cur_channel == mtm_pkg::MIDI_PERC_CH) begin
      mch = mtm_pkg::MUS_PERC_CH;
    end else begin
      mch = cur_channel;
    end
  end

  always_comb begin
    phase_next         = e_phase;
    halted_next        = e_halted;
    pending_delay_next = e_pd;
    cur_channel_next   = cur_channel;
    cur_event_next     = cur_event;
    group_last_next    = group_last;
    first_param_next   = first_param;
    vol_we             = 1'b0;
    do_emit            = 1'b0;
    rec_valid          = 1'b0;
    rec                = '0;
    rec.delay          = e_pd;
    rec.ngrp           = ngrp;
    rec.nbody          = 2'd3;
    rec.status         = mtm_pkg::ST_OK;
    if (fire && !e_halted) begin
      case (e_phase)
        PH_DESC: begin
          cur_channel_next = mus_byte[3:0];
          cur_event_next   = mus_byte[6:4];
          group_last_next  = mus_byte[7];
          if (mus_byte[6:4] == mtm_pkg::EV_SCORE_END) begin
            rec_valid          = 1'b1;
            rec.tend           = 1'b1;
            rec.body           = {8'h00, mtm_pkg::META_EOT, mtm_pkg::META_BYTE};
            pending_delay_next = '0;
            phase_next         = PH_DONE;
          end else if (mus_byte[6:4] == mtm_pkg::EV_BAD_A ||
                       mus_byte[6:4] == mtm_pkg::EV_BAD_B) begin
            rec_valid   = 1'b1;
            rec.ngrp    = '0;
            rec.nbody   = 2'd1;
            rec.status  = mtm_pkg::ST_BAD_EVT;
            halted_next = 1'b1;
          end else begin
            phase_next = PH_P1;
          end
        end
        PH_P1: begin
          first_param_next = mus_byte;
          case (cur_event)
            mtm_pkg::EV_RELEASE: begin
              do_emit  = 1'b1;
              rec.body = {8'h00, mus_byte, mtm_pkg::CMD_NOTE_OFF, mch};
            end
            mtm_pkg::EV_PLAY: begin
              if (mus_byte[7]) begin
                phase_next = PH_P2;
              end else begin
                do_emit  = 1'b1;
                rec.body = {mtm_pkg::clamp_vol(channel_volume[cur_channel]),
                            1'b0, mus_byte[6:0], mtm_pkg::CMD_NOTE_ON, mch};
              end
            end
            mtm_pkg::EV_PITCH: begin
              do_emit  = 1'b1;
              rec.body = {1'b0, mus_byte[7:1], 1'b0, mus_byte[0], 6'd0,
                          mtm_pkg::CMD_BEND, mch};
            end
            mtm_pkg::EV_SYSTEM: begin
              if (mus_byte > mtm_pkg::MAX_CTRL) begin
                rec_valid   = 1'b1;
                rec.ngrp    = '0;
                rec.nbody   = 2'd1;
                rec.status  = mtm_pkg::ST_BAD_CTRL;
                halted_next = 1'b1;
              end else begin
                do_emit  = 1'b1;
                rec.body = {8'h00, mtm_pkg::ctl_map(mus_byte[3:0]),
                            mtm_pkg::CMD_CTRL, mch};
              end
            end
            default: begin
              if (mus_byte > mtm_pkg::MAX_CTRL) begin
                rec_valid   = 1'b1;
                rec.ngrp    = '0;
                rec.nbody   = 2'd1;
                rec.status  = mtm_pkg::ST_BAD_CTRL;
                halted_next = 1'b1;
              end else begin
                phase_next = PH_P2;
              end
            end
          endcase
        end
        PH_P2: begin
          do_emit = 1'b1;
          if (cur_event == mtm_pkg::EV_PLAY) begin
            vol_we   = 1'b1;
            rec.body = {mtm_pkg::clamp_vol(mus_byte), 1'b0, first_param[6:0],
                        mtm_pkg::CMD_NOTE_ON, mch};
          end else if (first_param == 8'd0) begin
            rec.nbody = 2'd2;
            rec.body  = {8'h00, mus_byte, mtm_pkg::CMD_PROGRAM, mch};
          end else begin
            rec.body = {mus_byte,
                        mtm_pkg::ctl_map((first_param > mtm_pkg::MAX_CTRL) ?
                                         4'd0 : first_param[3:0]),
                        mtm_pkg::CMD_CTRL, mch};
          end
        end
        PH_DELAY: begin
          if (e_pd[mtm_pkg::DELAY_BITS-1 -: 7] != 7'd0) begin
            pending_delay_next = '1;
          end else begin
            pending_delay_next = {e_pd[mtm_pkg::DELAY_BITS-8:0], mus_byte[6:0]};
          end
          if (!mus_byte[7]) begin
            phase_next = PH_DESC;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
      if (do_emit) begin
        rec_valid          = 1'b1;
        pending_delay_next = '0;
        phase_next         = group_last ? PH_DELAY : PH_DESC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DESC;
      halted        <= 1'b0;
      cur_channel   <= '0;
      cur_event     <= '0;
      group_last    <= 1'b0;
      first_param   <= '0;
      pending_delay <= '0;
      for (int i = 0; i < mtm_pkg::NUM_CHANNELS; i++) begin
        channel_volume[i] <= mtm_pkg::VOL_RESET;
      end
    end else if (fire) begin
      phase         <= phase_next;
      halted        <= halted_next;
      cur_channel   <= cur_channel_next;
      cur_event     <= cur_event_next;
      group_last    <= group_last_next;
      first_param   <= first_param_next;
      pending_delay <= pending_delay_next;
      if (score_start) begin
        for (int i = 0; i < mtm_pkg::NUM_CHANNELS; i++) begin
          channel_volume[i] <= initial_volume;
        end
      end
      if (vol_we) begin
        channel_volume[cur_channel] <= mus_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/mtm_evq.sv =====
// Short event queue between the front and back ends of the transcoder.
// Holds event records; depends on mtm_pkg.
`default_nettype none
module mtm_evq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire mtm_pkg::event_t  wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output mtm_pkg::event_t       rd_data,
  output logic                  rd_valid
);

  mtm_pkg::event_t                 mem [mtm_pkg::EVQ_DEPTH];
  logic [mtm_pkg::EVQ_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [mtm_pkg::EVQ_PTR_W:0]     count;
  logic                            do_wr, do_rd;

  assign full     = (count == (mtm_pkg::EVQ_PTR_W + 1)'(mtm_pkg::EVQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mtm_back.sv =====
// Back end: walks the head event record one byte per cycle, delay groups first,
// into the output register while it is empty or popped. Depends on mtm_pkg.
`default_nettype none
module mtm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire mtm_pkg::event_t  q_rec,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            midi_byte,
  output logic                  run_last,
  output logic                  track_end,
  output logic [1:0]            status
);

  logic [mtm_pkg::STEP_W-1:0]  step, total, body_idx;
  logic [mtm_pkg::GRP_W-1:0]   g;
  logic [mtm_pkg::DPAD_W-1:0]  dpad;
  logic                        out_valid, advance, last, in_delay;
  logic [7:0]                  byte_sel;

  always_comb begin
    dpad     = mtm_pkg::DPAD_W'(q_rec.delay);
    total    = mtm_pkg::STEP_W'(q_rec.ngrp) + mtm_pkg::STEP_W'(q_rec.nbody);
    last     = (step == total - 1'b1);
    in_delay = (step < mtm_pkg::STEP_W'(q_rec.ngrp));
    g        = mtm_pkg::GRP_W'(mtm_pkg::STEP_W'(q_rec.ngrp) - step - 1'b1);
    body_idx = step - mtm_pkg::STEP_W'(q_rec.ngrp);
    if (in_delay) begin
      byte_sel = {(g != '0), dpad[g*7 +: 7]};
    end else begin
      byte_sel = q_rec.body[body_idx[1:0]];
    end
  end

  assign advance = q_valid && (!out_valid || pop);
  assign q_pop   = advance && last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= last ? '0 : step + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      midi_byte <= byte_sel;
      run_last  <= last;
      track_end <= q_rec.tend;
      status    <= q_rec.status;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mtm_checker.sv =====
// Port-level checker for the transcoder and the bind that attaches it.
// Depends on mtm_pkg and mus_to_midi_event_transcoder_core.
`default_nettype none
module mtm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] midi_byte,
  input wire logic       run_last,
  input wire logic       track_end,
  input wire logic [1:0] status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(midi_byte) && $stable(run_last)))
    else $error("Waiting beat changed before it was taken.");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != mtm_pkg::ST_OK) |->
      (midi_byte == 8'd0 && run_last && !track_end))
    else $error("Error beat is malformed.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status != mtm_pkg::ST_UNUSED)
    else $error("Unused status code on a result beat.");

  a_eot_tail: assert property (@(posedge clk) disable iff (rst)
    (!empty && track_end && run_last) |-> midi_byte == 8'd0)
    else $error("End-of-track run does not end in a zero byte.");

endmodule

bind mus_to_midi_event_transcoder_core mtm_checker u_mtm_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .midi_byte (midi_byte),
  .run_last  (run_last),
  .track_end (track_end),
  .status    (status)
);
`default_nettype wire

// ===== tb/sv/mus_to_midi_event_transcoder_core_tb.sv =====
// Self-checking testbench for mus_to_midi_event_transcoder_core: MUS bytes in, MIDI bytes out.
// A built-in transcoder predicts every output beat and checks each popped beat against it.
// Depends on mtm_pkg and the core RTL.
`default_nettype none
module mus_to_midi_event_transcoder_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_BYTES    = 50;
  localparam logic [mtm_pkg::APB_ADDR_W-1:0] VOL_ADDR =
    mtm_pkg::APB_ADDR_W'(4 * mtm_pkg::REG_INIT_VOL);
  localparam logic [mtm_pkg::APB_ADDR_W-1:0] SPARE_ADDR = mtm_pkg::APB_ADDR_W'(4);

  typedef enum logic [2:0] {
    AWAIT_DESC, AWAIT_P1, AWAIT_P2, AWAIT_DELAY, SCORE_DONE
  } parse_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } mus_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       tend;
    logic [1:0] st;
  } midi_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic push = 1'b0;
  logic full;
  logic [7:0] mus_byte = 8'd0;
  logic score_start = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] midi_byte;
  logic run_last;
  logic track_end;
  logic [1:0] status;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mtm_pkg::APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mus_item_t  mus_items[$];
  midi_beat_t midi_expect[$];
  midi_beat_t step_beats[$];

  logic [7:0] ctrl_xlate [15] = '{8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11, 8'd91, 8'd93,
                                  8'd64, 8'd67, 8'd120, 8'd123, 8'd126, 8'd127, 8'd121};

  logic [7:0]  init_vol;
  parse_t      phase;
  logic [3:0]  cur_ch;
  logic [2:0]  cur_ev;
  logic        grp_last;
  logic [7:0]  p1_byte;
  logic [27:0] pend_delay;
  logic [7:0]  chan_vol [16];
  logic        halted;

  logic gaps_on = 1'b1;
  bit   in_taken = 1'b0;
  bit   out_taken = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   quiet = 0;
  int   errors = 0;
  int   n_queued = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_eot = 0;
  int   n_fault = 0;

  mus_to_midi_event_transcoder_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mus_byte(mus_byte),
    .score_start(score_start), .empty(empty), .pop(pop), .midi_byte(midi_byte),
    .run_last(run_last), .track_end(track_end), .status(status), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] midi_ch(input logic [3:0] c);
    if (c == mtm_pkg::MUS_PERC_CH) return mtm_pkg::MIDI_PERC_CH;
    if (c == mtm_pkg::MIDI_PERC_CH) return mtm_pkg::MUS_PERC_CH;
    return c;
  endfunction

  function automatic logic [7:0] cap_vol(input logic [7:0] v);
    return (v > 8'd127) ? 8'd127 : v;
  endfunction

  task automatic emit(input logic [7:0] d, input logic te, input logic [1:0] st);
    step_beats.push_back(midi_beat_t'{data: d, is_last: 1'b0, tend: te, st: st});
  endtask

  task automatic emit_delay(input logic te);
    logic [6:0]  grp [5];
    logic [27:0] d;
    int          k;
    d = pend_delay;
    k = 0;
    if (d == 0) begin
      emit(8'h00, te, mtm_pkg::ST_OK);
    end else begin
      while (d != 0) begin
        grp[k] = d[6:0];
        d = d >> 7;
        k++;
      end
      for (int i = k - 1; i >= 0; i--) emit({i > 0, grp[i]}, te, mtm_pkg::ST_OK);
    end
    pend_delay = '0;
  endtask

  task automatic emit_event(input logic [3:0] cmd, input int nparm, input logic [7:0] p0,
                            input logic [7:0] p1);
    emit_delay(1'b0);
    emit({cmd, midi_ch(cur_ch)}, 1'b0, mtm_pkg::ST_OK);
    if (nparm > 0) emit(p0, 1'b0, mtm_pkg::ST_OK);
    if (nparm > 1) emit(p1, 1'b0, mtm_pkg::ST_OK);
    phase = grp_last ? AWAIT_DELAY : AWAIT_DESC;
  endtask

  task automatic halt_with(input logic [1:0] st);
    emit(8'h00, 1'b0, st);
    halted = 1'b1;
  endtask

  task automatic clear_score_state();
    phase = AWAIT_DESC;
    cur_ch = '0;
    cur_ev = '0;
    grp_last = 1'b0;
    p1_byte = '0;
    pend_delay = '0;
    halted = 1'b0;
    for (int i = 0; i < 16; i++) chan_vol[i] = init_vol;
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic start);
    logic [63:0] acc;
    step_beats.delete();
    if (start) clear_score_state();
    if (!halted && phase != SCORE_DONE) begin
      case (phase)
        AWAIT_DESC: begin
          cur_ch = b[3:0];
          cur_ev = b[6:4];
          grp_last = b[7];
          if (cur_ev == mtm_pkg::EV_SCORE_END) begin
            emit_delay(1'b1);
            emit(mtm_pkg::META_BYTE, 1'b1, mtm_pkg::ST_OK);
            emit(mtm_pkg::META_EOT, 1'b1, mtm_pkg::ST_OK);
            emit(8'h00, 1'b1, mtm_pkg::ST_OK);
            phase = SCORE_DONE;
          end else if (cur_ev == mtm_pkg::EV_BAD_A || cur_ev == mtm_pkg::EV_BAD_B) begin
            halt_with(mtm_pkg::ST_BAD_EVT);
          end else begin
            phase = AWAIT_P1;
          end
        end
        AWAIT_P1: begin
          p1_byte = b;
          case (cur_ev)
            mtm_pkg::EV_RELEASE: emit_event(mtm_pkg::CMD_NOTE_OFF, 2, b, 8'h00);
            mtm_pkg::EV_PLAY: begin
              if (b[7]) phase = AWAIT_P2;
              else emit_event(mtm_pkg::CMD_NOTE_ON, 2, {1'b0, b[6:0]},
                              cap_vol(chan_vol[cur_ch]));
            end
            mtm_pkg::EV_PITCH: emit_event(mtm_pkg::CMD_BEND, 2, {1'b0, b[0], 6'b0},
                                          {1'b0, b[7:1]});
            mtm_pkg::EV_SYSTEM: begin
              if (b > mtm_pkg::MAX_CTRL) halt_with(mtm_pkg::ST_BAD_CTRL);
              else emit_event(mtm_pkg::CMD_CTRL, 2, ctrl_xlate[b[3:0]], 8'h00);
            end
            default: begin
              if (b > mtm_pkg::MAX_CTRL) halt_with(mtm_pkg::ST_BAD_CTRL);
              else phase = AWAIT_P2;
            end
          endcase
        end
        AWAIT_P2: begin
          if (cur_ev == mtm_pkg::EV_PLAY) begin
            chan_vol[cur_ch] = b;
            emit_event(mtm_pkg::CMD_NOTE_ON, 2, {1'b0, p1_byte[6:0]}, cap_vol(b));
          end else if (p1_byte == 8'd0) begin
            emit_event(mtm_pkg::CMD_PROGRAM, 1, b, 8'h00);
          end else begin
            emit_event(mtm_pkg::CMD_CTRL, 2, ctrl_xlate[p1_byte[3:0]], b);
          end
        end
        AWAIT_DELAY: begin
          acc = ({36'd0, pend_delay} << 7) + 64'(b[6:0]);
          if (acc > 64'h0fff_ffff) acc = 64'h0fff_ffff;
          pend_delay = acc[27:0];
          if (!b[7]) phase = AWAIT_DESC;
        end
        default: phase = SCORE_DONE;
      endcase
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].is_last = 1'b1;
    foreach (step_beats[i]) midi_expect.push_back(step_beats[i]);
  endtask

  task automatic check_beat();
    midi_beat_t want;
    n_out++;
    if (track_end && run_last) n_eot++;
    if (status != mtm_pkg::ST_OK) n_fault++;
    if (midi_expect.size() == 0) begin
      flag_mismatch("unexpected beat, midi_byte", midi_byte, 0);
    end else begin
      want = midi_expect.pop_front();
      if (midi_byte !== want.data) flag_mismatch("midi_byte", midi_byte, want.data);
      if (run_last !== want.is_last) flag_mismatch("run_last", run_last, want.is_last);
      if (track_end !== want.tend) flag_mismatch("track_end", track_end, want.tend);
      if (status !== want.st) flag_mismatch("status", status, want.st);
    end
  endtask

  always @(posedge clk) begin
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        out_taken = 1'b1;
        check_beat();
      end
      if (push && !full) begin
        in_taken = 1'b1;
        transcode_byte(mus_byte, score_start);
        void'(mus_items.pop_front());
        n_in++;
      end
      if (in_taken || out_taken || psel) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (in_gap > 0) begin
        push <= 1'b0;
        in_gap--;
      end else if (mus_items.size() > 0) begin
        push <= 1'b1;
        mus_byte <= mus_items[0].data;
        score_start <= mus_items[0].start;
        in_gap = draw_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) out_gap = draw_gap();
      if (out_gap > 0) begin
        pop <= 1'b0;
        out_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic s);
    mus_items.push_back(mus_item_t'{data: b, start: s});
    n_queued++;
  endtask

  task automatic add_delay();
    int r;
    int nd;
    r = $urandom_range(0, 99);
    if (r < 10) nd = 0;
    else if (r < 80) nd = $urandom_range(1, 3);
    else if (r < 95) nd = 4;
    else nd = 5;
    if (nd == 0) add_byte(8'h00, 1'b0);
    for (int i = 0; i < nd; i++) add_byte({i < nd - 1, 7'($urandom_range(0, 127))}, 1'b0);
  endtask

  function automatic logic [7:0] pick_ctrl();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(15, 255));
    return 8'($urandom_range(0, 14));
  endfunction

  task automatic add_event(input logic is_first, output logic stopped);
    int         r;
    logic       lst;
    logic [3:0] ch;
    logic [7:0] p;
    r = $urandom_range(0, 99);
    lst = ($urandom_range(0, 9) < 4);
    ch = 4'($urandom_range(0, 15));
    stopped = 1'b0;
    if (r < 20) begin
      add_byte({lst, mtm_pkg::EV_RELEASE, ch}, is_first);
      add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 45) begin
      p = 8'($urandom_range(0, 255));
      add_byte({lst, mtm_pkg::EV_PLAY, ch}, is_first);
      add_byte(p, 1'b0);
      if (p[7]) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 55) begin
      add_byte({lst, mtm_pkg::EV_PITCH, ch}, is_first);
      add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 65) begin
      p = pick_ctrl();
      add_byte({lst, mtm_pkg::EV_SYSTEM, ch}, is_first);
      add_byte(p, 1'b0);
      stopped = (p > mtm_pkg::MAX_CTRL);
    end else if (r < 88) begin
      p = pick_ctrl();
      add_byte({lst, mtm_pkg::EV_CONTROL, ch}, is_first);
      add_byte(p, 1'b0);
      if (p <= mtm_pkg::MAX_CTRL) add_byte(8'($urandom_range(0, 255)), 1'b0);
      stopped = (p > mtm_pkg::MAX_CTRL);
    end else if (r < 92) begin
      add_byte({lst, ($urandom_range(0, 1) != 0) ? mtm_pkg::EV_BAD_A : mtm_pkg::EV_BAD_B, ch},
               is_first);
      stopped = 1'b1;
    end else begin
      add_byte({lst, mtm_pkg::EV_SCORE_END, ch}, is_first);
      stopped = 1'b1;
    end
    if (!stopped && lst) add_delay();
  endtask

  task automatic add_score();
    int   n;
    logic stopped;
    n = $urandom_range(2, 10);
    stopped = 1'b0;
    for (int i = 0; i < n && !stopped; i++) add_event(i == 0, stopped);
    if (!stopped && $urandom_range(0, 9) < 7) begin
      add_byte({1'($urandom_range(0, 1)), mtm_pkg::EV_SCORE_END, 4'($urandom_range(0, 15))},
               1'b0);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic add_directed();
    add_byte({1'b0, mtm_pkg::EV_PLAY, 4'd15}, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(8'hc8, 1'b0);
    add_byte({1'b1, mtm_pkg::EV_RELEASE, 4'd9}, 1'b0);
    add_byte(8'h00, 1'b0);
    repeat (4) add_byte(8'hff, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_PITCH, 4'd15}, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_SYSTEM, 4'd15}, 1'b0);
    add_byte(8'h0e, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_CONTROL, 4'd0}, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hab, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_CONTROL, 4'd5}, 1'b0);
    add_byte(8'h0d, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_PLAY, 4'd5}, 1'b0);
    add_byte(8'h3c, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_CONTROL, 4'd3}, 1'b0);
    add_byte(8'h0f, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_BAD_A, 4'd0}, 1'b1);
    add_byte({1'b0, mtm_pkg::EV_SCORE_END, 4'd0}, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte({1'b0, mtm_pkg::EV_BAD_B, 4'd0}, 1'b1);
  endtask

  task automatic apb_write(input logic [mtm_pkg::APB_ADDR_W-1:0] a, input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == VOL_ADDR) init_vol = d[7:0];
  endtask

  task automatic check_volume_reg();
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= VOL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {24'd0, init_vol}) flag_mismatch("initial_volume readback", got, init_vol);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (mus_items.size() > 0 || push || midi_expect.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [7:0] vols [4];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    init_vol = mtm_pkg::VOL_RESET;
    clear_score_state();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    check_volume_reg();
    add_directed();
    wait_idle();
    vols = '{8'd255, 8'd0, 8'd128, 8'($urandom_range(1, 254))};
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(VOL_ADDR, {24'd0, vols[ph]});
      if (ph == 2) apb_write(SPARE_ADDR, $urandom);
      check_volume_reg();
      gaps_on = (ph != 0);
      n_queued = 0;
      while (n_queued < PHASE_BYTES) add_score();
      wait_idle();
    end
    $display("Run fed %0d score bytes and checked %0d MIDI beats under five volume settings.",
             n_in, n_out);
    $display("Scores closed with end-of-track: %0d, halting error beats: %0d.", n_eot, n_fault);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
